### rtl/swap_block_bitmap_allocator_defines.svh
// assertion macros shared by the checker
`ifndef SWAP_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define SWAP_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// checked on every clock edge outside reset
`define SBBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define SBBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/sbba_pkg.sv
package sbba_pkg;

  // map geometry
  localparam int unsigned NUM_BLOCKS = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);

  // field widths
  localparam int unsigned BLK_W = 12;
  localparam int unsigned ST_W  = 2;

  // reciprocal for block number / WORD_BITS, exact for 12-bit block numbers
  localparam int unsigned DIV_SH = 24;
  localparam int unsigned RECIP  = ((2 ** DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PROD_W = 40;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // bits of the last map word that stand for real blocks
  function automatic map_word_t last_word_mask();
    map_word_t m;
    m = '0;
    for (int b = 0; b < int'(WORD_BITS); b++) begin
      m[b] = (((MAP_WORDS - 1) * WORD_BITS) + b) < NUM_BLOCKS;
    end
    return m;
  endfunction

  localparam map_word_t LAST_MASK = last_word_mask();

endpackage

### rtl/sbba_if.sv
// request channel: opcode and block number
interface sbba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [sbba_pkg::BLK_W-1:0]  block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

// response channel: granted block and status
interface sbba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sbba_pkg::BLK_W-1:0]  granted_block;
  logic [sbba_pkg::ST_W-1:0]   status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface

### rtl/swap_block_bitmap_allocator.sv
// First-fit swap block allocator. The free map lives in a single-port-read,
// single-port-write RAM of MAP_WORDS words (128 x 32 bits by default); a set bit marks a
// free block and every block is free after reset (per-word valid flags stand in for the
// initial all-ones content, so no clearing pass is needed). One request is handled at a
// time. An allocate reads one map word per cycle from word 0 upward and stops at the first
// word holding a free block; on a full map it reads every word through the RAM read port
// before it answers full. A free goes through index computation and the read of the map
// word, then write back of the modified word. A response waiting in the output register
// stalls the block only when the next response is ready to be written.
module swap_block_bitmap_allocator (
  input  logic     clk_i,
  input  logic     rst_ni,
  sbba_req_if.sink   req_i,
  sbba_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIDX = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  localparam int unsigned WIDX_W = sbba_pkg::WIDX_W;
  localparam int unsigned BIT_W  = sbba_pkg::BIT_W;
  localparam int unsigned BLK_W  = sbba_pkg::BLK_W;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(sbba_pkg::MAP_WORDS - 1);

  logic [1:0]               state_q, state_d;
  logic [BLK_W-1:0]         blk_q, blk_d;
  logic [WIDX_W-1:0]        word_q, word_d;
  logic [WIDX_W-1:0]        chk_q, chk_d;
  logic                     rd_vld_q;
  logic [sbba_pkg::MAP_WORDS-1:0] valid_q;

  logic                     rsp_valid_q, rsp_valid_d;
  logic [BLK_W-1:0]         rsp_granted_q, rsp_granted_d;
  sbba_pkg::status_e        rsp_status_q, rsp_status_d;

  logic                     rd_en, wr_en;
  logic [WIDX_W-1:0]        rd_addr, wr_addr;
  sbba_pkg::map_word_t      rd_data, wr_data;

  logic                     accept, slot_free;
  sbba_pkg::map_word_t      cur_word, scan_word;
  logic [BIT_W-1:0]         low_bit, free_bit;
  logic [sbba_pkg::PROD_W-1:0] quot_prod;
  logic [WIDX_W-1:0]        quot_idx;
  logic [31:0]              free_off, found_blk;
  logic                     in_range;

  // free map storage
  sbba_map_ram #(
    .DEPTH (sbba_pkg::MAP_WORDS),
    .WIDTH (sbba_pkg::WORD_BITS)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.granted_block = rsp_granted_q;
  assign rsp_o.status        = rsp_status_q;

  // word read back, never-written words read as all free
  assign cur_word  = rd_vld_q ? rd_data : '1;
  assign scan_word = (chk_q == LAST_WORD) ? (cur_word & sbba_pkg::LAST_MASK) : cur_word;

  // lowest free bit of the scanned word
  always_comb begin
    low_bit = '0;
    for (int i = int'(sbba_pkg::WORD_BITS) - 1; i >= 0; i--) begin
      if (scan_word[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  assign found_blk = (32'(chk_q) * 32'(sbba_pkg::WORD_BITS)) + 32'(low_bit);

  // block number split into word index and bit offset
  assign quot_prod = sbba_pkg::PROD_W'(blk_q) * sbba_pkg::PROD_W'(sbba_pkg::RECIP);
  assign quot_idx  = WIDX_W'(quot_prod >> sbba_pkg::DIV_SH);
  assign free_off  = 32'(blk_q) - (32'(word_q) * 32'(sbba_pkg::WORD_BITS));
  assign free_bit  = free_off[BIT_W-1:0];
  assign in_range  = 32'(blk_q) < sbba_pkg::NUM_BLOCKS;

  // request sequencing
  always_comb begin
    state_d       = state_q;
    blk_d         = blk_q;
    word_d        = word_q;
    chk_d         = chk_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = word_q;
    wr_data       = cur_word;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_granted_d = rsp_granted_q;
    rsp_status_d  = rsp_status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == sbba_pkg::OP_FREE) begin
            blk_d   = req_i.block_number;
            state_d = S_FIDX;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            chk_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_FIDX: begin
        rd_en   = 1'b1;
        rd_addr = quot_idx;
        word_d  = quot_idx;
        state_d = S_FREE;
      end
      S_FREE: begin
        if (slot_free) begin
          rsp_valid_d   = 1'b1;
          rsp_granted_d = '0;
          if (in_range) begin
            wr_en        = 1'b1;
            wr_addr      = word_q;
            wr_data      = cur_word | (sbba_pkg::map_word_t'(1) << free_bit);
            rsp_status_d = sbba_pkg::ST_OK;
          end else begin
            rsp_status_d = sbba_pkg::ST_RANGE;
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (|scan_word) begin
          if (slot_free) begin
            wr_en         = 1'b1;
            wr_addr       = chk_q;
            wr_data       = cur_word & ~(sbba_pkg::map_word_t'(1) << low_bit);
            rsp_valid_d   = 1'b1;
            rsp_granted_d = found_blk[BLK_W-1:0];
            rsp_status_d  = sbba_pkg::ST_OK;
            state_d       = S_IDLE;
          end
        end else if (chk_q == LAST_WORD) begin
          if (slot_free) begin
            rsp_valid_d   = 1'b1;
            rsp_granted_d = '0;
            rsp_status_d  = sbba_pkg::ST_FULL;
            state_d       = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_q + WIDX_W'(1);
          chk_d   = chk_q + WIDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    blk_q         <= blk_d;
    word_q        <= word_d;
    chk_q         <= chk_d;
    rsp_granted_q <= rsp_granted_d;
    rsp_status_q  <= rsp_status_d;
  end

endmodule

### rtl/sbba_map_ram.sv
module sbba_map_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/sbba_checker.sv
`include "swap_block_bitmap_allocator_defines.svh"

module sbba_port_checks (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [sbba_pkg::BLK_W-1:0] rsp_granted_block_i,
  input logic [sbba_pkg::ST_W-1:0]  rsp_status_i
);

  logic                                     rsp_fail;
  logic                                     rsp_stall;
  logic [sbba_pkg::BLK_W+sbba_pkg::ST_W-1:0] rsp_payload;

  assign rsp_fail    = rsp_valid_i && (rsp_status_i != sbba_pkg::ST_OK);
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_payload = {rsp_granted_block_i, rsp_status_i};

  // no response is pending right after reset
  `SBBA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !rsp_valid_i, "response valid after reset")

  // one request at a time: intake closes after an accept
  `SBBA_ASSERT(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "request while busy")

  // failed requests carry no block number; frees also answer zero, but only failures are checked
  `SBBA_ASSERT(a_zero_on_fail, rsp_fail |-> rsp_granted_block_i == '0, "block on failed request")

  // only known status codes leave the block
  `SBBA_ASSERT(a_status_code, rsp_valid_i |-> rsp_status_i <= sbba_pkg::ST_RANGE, "bad status")

  // stalled response holds
  `SBBA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid_i && $stable(rsp_payload), "response changed")

endmodule

bind swap_block_bitmap_allocator sbba_port_checks u_sbba_port_checks (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_granted_block_i (rsp_o.granted_block),
  .rsp_status_i        (rsp_o.status)
);

### sim/sbba_checker.sv
// watches both channels, predicts each response from its own free map
// and compares the responses in order
module sbba_checker
  import sbba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbba_req_if         req_i,
  sbba_rsp_if         rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned grants_o,
  output int unsigned full_answers_o,
  output int unsigned frees_o
);

  typedef struct packed {
    logic [BLK_W-1:0] granted;
    status_e          status;
  } alloc_rsp_t;

  // one bit per block, set means free
  bit [NUM_BLOCKS-1:0] free_map;
  alloc_rsp_t          owed_answers_q[$];
  int unsigned         mismatch_cnt;
  int unsigned         grant_cnt;
  int unsigned         full_cnt;
  int unsigned         free_cnt;

  // first fit over the free map, updates the map and gives the answer
  function automatic alloc_rsp_t first_fit_step(input op_e op, input logic [BLK_W-1:0] blk);
    alloc_rsp_t  ans;
    bit          hit;
    int unsigned pick;
    ans.granted = '0;
    ans.status  = ST_OK;
    hit         = 1'b0;
    pick        = 0;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < int'(NUM_BLOCKS); i++) begin
        if (!hit && free_map[i]) begin
          hit  = 1'b1;
          pick = i;
        end
      end
      if (hit) begin
        free_map[pick] = 1'b0;
        ans.granted    = pick[BLK_W-1:0];
        grant_cnt++;
      end else begin
        ans.status = ST_FULL;
        full_cnt++;
      end
    end else begin
      if (32'(blk) >= NUM_BLOCKS) begin
        ans.status = ST_RANGE;
      end else begin
        free_map[blk] = 1'b1;
        free_cnt++;
      end
    end
    return ans;
  endfunction

  // response check first, then prediction of the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    if (!rst_ni) begin
      free_map = '1;
      owed_answers_q.delete();
      mismatch_cnt = 0;
      grant_cnt    = 0;
      full_cnt     = 0;
      free_cnt     = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_answers_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: response with no request outstanding (granted %0d status %0d)",
                     $time, rsp_i.granted_block, rsp_i.status);
          end
        end else begin
          want = owed_answers_q.pop_front();
          if (rsp_i.granted_block !== want.granted || rsp_i.status !== want.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch granted exp %0d got %0d, status exp %0d got %0d",
                       $time, want.granted, rsp_i.granted_block, want.status, rsp_i.status);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        owed_answers_q.push_back(first_fit_step(op_e'(req_i.opcode), req_i.block_number));
      end
    end
    mismatches_o   <= mismatch_cnt;
    pending_o      <= owed_answers_q.size();
    grants_o       <= grant_cnt;
    full_answers_o <= full_cnt;
    frees_o        <= free_cnt;
  end

endmodule

### sim/tb.sv
// stimulus and verdict for the swap block allocator
module tb;
  import sbba_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned grants;
  int unsigned full_answers;
  int unsigned frees;
  int unsigned burst_left = 0;

  sbba_req_if req_if ();
  sbba_rsp_if rsp_if ();

  swap_block_bitmap_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sbba_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .grants_o       (grants),
    .full_answers_o (full_answers),
    .frees_o        (frees)
  );

  always #5 clk_i = ~clk_i;

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: requests or responses stopped moving");
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [BLK_W-1:0] any_block();
    return BLK_W'($urandom_range(0, (1 << BLK_W) - 1));
  endfunction

  // offer one request in bursts with random gaps, wait until it is taken
  task automatic send_req(input op_e op, input logic [BLK_W-1:0] blk);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.block_number <= blk;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
  endtask

  // receiver: ready runs and stalls, one long hold-off while requests keep coming
  initial begin
    int unsigned rsp_seen;
    int unsigned run_left;
    int unsigned hold_left;
    bit          stalling;
    bit          held;
    rsp_seen  = 0;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b0;
    held      = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) rsp_seen++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!held && rsp_seen >= 30) begin
        held      = 1'b1;
        hold_left = 400;
        rsp_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          if (stalling) run_left = $urandom_range(1, 8);
          else run_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
        end
        run_left--;
        rsp_if.ready <= !stalling;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned waited;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_ALLOC;
    req_if.block_number <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fresh map: lowest blocks first, block field ignored on allocate
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '1);
    send_req(OP_ALLOC, 12'h555);
    send_req(OP_FREE, 12'd1);
    send_req(OP_ALLOC, 12'haaa);
    // double frees of never used and just freed blocks
    send_req(OP_FREE, '1);
    send_req(OP_FREE, 12'd2048);
    send_req(OP_FREE, '0);
    send_req(OP_FREE, '0);
    send_req(OP_ALLOC, '0);

    // grow the used range over several map words
    repeat (300) send_req(OP_ALLOC, any_block());

    // single holes at a word boundary and deep in the used range
    send_req(OP_FREE, 12'd31);
    send_req(OP_FREE, 12'd32);
    send_req(OP_FREE, 12'd200);
    send_req(OP_ALLOC, '1);
    send_req(OP_ALLOC, '1);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, '1);

    // random traffic, frees biased to low blocks
    repeat (180) begin
      if ($urandom_range(0, 99) < 55) send_req(OP_ALLOC, any_block());
      else if ($urandom_range(0, 1) == 1) send_req(OP_FREE, BLK_W'($urandom_range(0, 511)));
      else send_req(OP_FREE, any_block());
    end
    req_if.valid <= 1'b0;

    // drain, then give the block time to show stray responses
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);

    $display("run: %0d blocks granted, %0d full answers, %0d frees", grants, full_answers,
             frees);
    $display("map grown over several words, holes reopened, then mixed random traffic");
    if (pending != 0) $display("%0d responses never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
